>>> design/hufd_pkg.sv
// ----------------------------------------------------------------------------
// Huffman tree bit decoder package
// Shared types, constants and status codes of the tree decoder.
// ----------------------------------------------------------------------------
package hufd_pkg;

	localparam int NODE_COUNT_DEF   = 512;
	localparam int MAX_CODE_LEN_DEF = 32;

	localparam int SYM_W     = 8;
	localparam int LEN_W     = 6;
	localparam int CODE_W    = 32;
	localparam int STATUS_W  = 3;

	typedef enum logic [0:0] {
		FUNC_LOAD   = 1'b0,
		FUNC_DECODE = 1'b1
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_BIT_TAKEN = 3'd0,
		ST_SYMBOL    = 3'd1,
		ST_INVALID   = 3'd2,
		ST_LOAD_OK   = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD_WALK,
		S_LOAD_CHAIN,
		S_DEC_STEP,
		S_DEC_LEAF,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic             valid;
		status_t          status;
		logic [SYM_W-1:0] sym;
	} res_t;

endpackage

>>> design/hufd_in_if.sv
// ----------------------------------------------------------------------------
// Huffman tree bit decoder request channel
// Valid/ready channel that carries one load or decode request.
// ----------------------------------------------------------------------------
interface hufd_in_if
	import hufd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [0:0]        func;
	logic [SYM_W-1:0]  symbol;
	logic [LEN_W-1:0]  code_length;
	logic [CODE_W-1:0] code_bits;
	logic [0:0]        stream_bit;

	modport source (
		output valid, func, symbol, code_length, code_bits, stream_bit,
		input  ready
	);

	modport sink (
		input  valid, func, symbol, code_length, code_bits, stream_bit,
		output ready
	);

endinterface

>>> design/hufd_out_if.sv
// ----------------------------------------------------------------------------
// Huffman tree bit decoder result channel
// Valid/ready channel that carries one status and decoded symbol.
// ----------------------------------------------------------------------------
interface hufd_out_if
	import hufd_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SYM_W-1:0]    decoded_symbol;

	modport source (
		output valid, status, decoded_symbol,
		input  ready
	);

	modport sink (
		input  valid, status, decoded_symbol,
		output ready
	);

endinterface

>>> design/hufd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hufd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/hufd_seq.sv
// ----------------------------------------------------------------------------
// Huffman tree bit decoder sequencer
// Walks the code tree one node per step through the node memory, both to
// insert codes and to decode stream bits.
// ----------------------------------------------------------------------------
module hufd_seq
	import hufd_pkg::*;
#(
	parameter int NODE_COUNT   = NODE_COUNT_DEF,
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hufd_in_if.sink    request,
	output res_t       res,
	input  logic       res_ready
);

	localparam int IDXW   = $clog2(NODE_COUNT);
	localparam int CNTW   = $clog2(MAX_CODE_LEN + 1);
	localparam int FREEW  = IDXW + 1;
	localparam int SUMW   = ((FREEW > CNTW) ? FREEW : CNTW) + 1;
	localparam int NODE_W = 2 * IDXW + SYM_W;

	typedef struct packed {
		logic [IDXW-1:0]  left;
		logic [IDXW-1:0]  right;
		logic [SYM_W-1:0] sym;
	} node_t;

	seq_state_t state_q, state_d;

	logic [IDXW-1:0]   root_left_q, root_left_d;
	logic [IDXW-1:0]   root_right_q, root_right_d;
	logic [FREEW-1:0]  next_free_q, next_free_d;
	logic [IDXW-1:0]   walk_q, walk_d;
	logic [IDXW-1:0]   cur_q, cur_d;
	logic [CNTW-1:0]   rem_q, rem_d;
	logic [CODE_W-1:0] code_q, code_d;
	logic [SYM_W-1:0]  sym_q, sym_d;
	logic              bit_q, bit_d;
	status_t           res_status_q, res_status_d;
	logic [SYM_W-1:0]  res_sym_q, res_sym_d;

	logic              ram_we;
	logic [IDXW-1:0]   ram_waddr;
	node_t             ram_wdata;
	logic              ram_re;
	logic [IDXW-1:0]   ram_raddr;
	logic [NODE_W-1:0] ram_rdata;

	node_t             rd_node;
	node_t             cur_node;
	node_t             link_node;
	node_t             chain_node;
	logic [CNTW-1:0]   rem_m1;
	logic              walk_bit;
	logic [IDXW-1:0]   walk_nx;
	logic [IDXW-1:0]   dec_nx;
	logic [IDXW-1:0]   free_idx;
	logic [IDXW-1:0]   free_idx_p1;
	logic              store_full;
	logic [CNTW-1:0]   len_eff;

	function automatic logic code_bit_at(input logic [CODE_W-1:0] code,
	                                     input logic [CNTW-1:0] pos);
		logic r;
		r = 1'b0;
		if (32'(pos) < CODE_W) begin
			r = code[5'(pos)];
		end
		return r;
	endfunction

	hufd_ram #(
		.WIDTH(NODE_W),
		.DEPTH(NODE_COUNT)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_node     = node_t'(ram_rdata);
	assign free_idx    = next_free_q[IDXW-1:0];
	assign free_idx_p1 = IDXW'(next_free_q + FREEW'(1));
	assign rem_m1      = rem_q - CNTW'(1);
	assign walk_bit    = code_bit_at(code_q, rem_m1);
	assign store_full  = (SUMW'(next_free_q) + SUMW'(rem_q)) > SUMW'(NODE_COUNT);

	always_comb begin
		if (cur_q == '0) begin
			cur_node = '{left: root_left_q, right: root_right_q, sym: '0};
		end else begin
			cur_node = rd_node;
		end
	end

	assign walk_nx = walk_bit ? cur_node.right : cur_node.left;
	assign dec_nx  = bit_q ? cur_node.right : cur_node.left;

	always_comb begin
		link_node = cur_node;
		if (walk_bit) begin
			link_node.right = free_idx;
		end else begin
			link_node.left = free_idx;
		end
	end

	always_comb begin
		chain_node = '0;
		if (rem_q == '0) begin
			chain_node.sym = sym_q;
		end else if (walk_bit) begin
			chain_node.right = free_idx_p1;
		end else begin
			chain_node.left = free_idx_p1;
		end
	end

	always_comb begin
		if (32'(request.code_length) > MAX_CODE_LEN) begin
			len_eff = CNTW'(MAX_CODE_LEN);
		end else begin
			len_eff = CNTW'(request.code_length);
		end
	end

	assign request.ready = (state_q == S_IDLE);
	assign res.valid     = (state_q == S_DONE);
	assign res.status    = res_status_q;
	assign res.sym       = res_sym_q;

	always_comb begin
		state_d      = state_q;
		root_left_d  = root_left_q;
		root_right_d = root_right_q;
		next_free_d  = next_free_q;
		walk_d       = walk_q;
		cur_d        = cur_q;
		rem_d        = rem_q;
		code_d       = code_q;
		sym_d        = sym_q;
		bit_d        = bit_q;
		res_status_d = res_status_q;
		res_sym_d    = res_sym_q;
		ram_we       = 1'b0;
		ram_waddr    = cur_q;
		ram_wdata    = chain_node;
		ram_re       = 1'b0;
		ram_raddr    = walk_nx;

		unique case (state_q)
			S_IDLE: begin
				if (request.valid) begin
					res_sym_d = '0;
					if (func_t'(request.func) == FUNC_DECODE) begin
						bit_d     = request.stream_bit;
						cur_d     = walk_q;
						ram_re    = 1'b1;
						ram_raddr = walk_q;
						state_d   = S_DEC_STEP;
					end else if (request.code_length == '0) begin
						res_status_d = ST_LOAD_OK;
						state_d      = S_DONE;
					end else begin
						code_d  = request.code_bits;
						sym_d   = request.symbol;
						rem_d   = len_eff;
						cur_d   = '0;
						state_d = S_LOAD_WALK;
					end
				end
			end
			S_LOAD_WALK: begin
				if (rem_q == '0) begin
					ram_we       = 1'b1;
					ram_wdata    = '{left: '0, right: '0, sym: sym_q};
					res_status_d = ST_LOAD_OK;
					state_d      = S_DONE;
				end else if (walk_nx != '0) begin
					ram_re = 1'b1;
					cur_d  = walk_nx;
					rem_d  = rem_m1;
				end else if (store_full) begin
					res_status_d = ST_FULL;
					state_d      = S_DONE;
				end else begin
					if (cur_q == '0) begin
						root_left_d  = link_node.left;
						root_right_d = link_node.right;
					end else begin
						ram_we    = 1'b1;
						ram_wdata = link_node;
					end
					cur_d   = free_idx;
					rem_d   = rem_m1;
					state_d = S_LOAD_CHAIN;
				end
			end
			S_LOAD_CHAIN: begin
				ram_we      = 1'b1;
				ram_wdata   = chain_node;
				next_free_d = next_free_q + FREEW'(1);
				if (rem_q == '0) begin
					res_status_d = ST_LOAD_OK;
					state_d      = S_DONE;
				end else begin
					cur_d = free_idx_p1;
					rem_d = rem_m1;
				end
			end
			S_DEC_STEP: begin
				if (dec_nx == '0) begin
					walk_d       = '0;
					res_status_d = ST_INVALID;
					state_d      = S_DONE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = dec_nx;
					cur_d     = dec_nx;
					state_d   = S_DEC_LEAF;
				end
			end
			S_DEC_LEAF: begin
				if (rd_node.left == '0 && rd_node.right == '0) begin
					walk_d       = '0;
					res_status_d = ST_SYMBOL;
					res_sym_d    = rd_node.sym;
				end else begin
					walk_d       = cur_q;
					res_status_d = ST_BIT_TAKEN;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			root_left_q  <= '0;
			root_right_q <= '0;
			next_free_q  <= FREEW'(1);
			walk_q       <= '0;
		end else begin
			state_q      <= state_d;
			root_left_q  <= root_left_d;
			root_right_q <= root_right_d;
			next_free_q  <= next_free_d;
			walk_q       <= walk_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q        <= cur_d;
		rem_q        <= rem_d;
		code_q       <= code_d;
		sym_q        <= sym_d;
		bit_q        <= bit_d;
		res_status_q <= res_status_d;
		res_sym_q    <= res_sym_d;
	end

endmodule

>>> design/huffman_tree_bit_decoder_core.sv
// ----------------------------------------------------------------------------
// Huffman tree bit decoder core
// A decode request reads the current node, steps to the child that the stream
// bit picks and reads that node to see whether it is a leaf; an invalid code
// ends after the step. The block is ready again while that result is presented.
// A load request of length L, saturated to MAX_CODE_LEN, makes one node memory
// read per existing tree level, then one memory write per created node.
// Reset clears the root and the walk position and sets the free node counter
// to one at once.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder_core
	import hufd_pkg::*;
#(
	parameter int NODE_COUNT   = NODE_COUNT_DEF,
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hufd_in_if.sink     request,
	hufd_out_if.source  result
);

	res_t                res;
	logic                res_ready;
	logic                out_vld_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [SYM_W-1:0]    out_sym_q;

	hufd_seq #(
		.NODE_COUNT   (NODE_COUNT),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.res       (res),
		.res_ready (res_ready)
	);

	assign res_ready = !out_vld_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_status_q <= res.status;
			out_sym_q    <= res.sym;
		end
	end

	assign result.valid          = out_vld_q;
	assign result.status         = out_status_q;
	assign result.decoded_symbol = out_sym_q;

endmodule

>>> tb/tb_huffman_tree_bit_decoder_core.sv
// ----------------------------------------------------------------------------
// Huffman tree bit decoder core testbench
// Loads random prefix codes into the decoder and walks bit streams through
// them. Every status and decoded symbol is checked against a behavioral model
// of the code tree. Requests and results see several patterns of gaps and
// back-pressure. Near its end the run fills the node store.
// ----------------------------------------------------------------------------
module tb_huffman_tree_bit_decoder_core;
	import hufd_pkg::*;

	localparam int NODE_COUNT   = NODE_COUNT_DEF;
	localparam int MAX_CODE_LEN = MAX_CODE_LEN_DEF;
	localparam int NODE_CAP     = NODE_COUNT - 64;
	localparam int RANDOM_ITEMS = 1000;

	localparam int CHECK_COPY = 0;
	localparam int STIM_COPY  = 1;

	localparam logic [1:0] MODE_FLAT      = 2'd0;
	localparam logic [1:0] MODE_SLOW_SRC  = 2'd1;
	localparam logic [1:0] MODE_SLOW_SINK = 2'd2;
	localparam logic [1:0] MODE_BOTH      = 2'd3;

	typedef struct packed {
		func_t             func;
		logic [SYM_W-1:0]  symbol;
		logic [LEN_W-1:0]  code_length;
		logic [CODE_W-1:0] code_bits;
		logic              stream_bit;
	} hufd_req_t;

	typedef struct packed {
		status_t          status;
		logic [SYM_W-1:0] sym;
	} hufd_res_t;

	typedef struct packed {
		hufd_req_t  req;
		logic [1:0] mode;
		logic       drain;
	} queued_req_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	hufd_in_if  req_bus ();
	hufd_out_if res_bus ();

	huffman_tree_bit_decoder_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_bus),
		.result (res_bus)
	);

	always #10 clk = ~clk;

	// Two copies of the code tree: one follows accepted requests, the other
	// runs ahead while the stimulus is built.
	int unsigned      left_kid  [2][NODE_COUNT];
	int unsigned      right_kid [2][NODE_COUNT];
	bit [SYM_W-1:0]   leaf_sym  [2][NODE_COUNT];
	int unsigned      next_node [2] = '{1, 1};
	int unsigned      walk_at   [2] = '{0, 0};

	queued_req_t       req_queue [$];
	hufd_res_t         expect_q  [$];
	logic [CODE_W-1:0] tab_code  [$];
	int                tab_len   [$];

	queued_req_t head;
	hufd_req_t   seen;
	hufd_res_t   want;
	logic [1:0]  gen_mode   = MODE_FLAT;
	logic [1:0]  run_mode   = MODE_FLAT;
	bit          drain_next = 1'b0;
	bit          req_fired  = 1'b0;
	int          queued_cnt = 0;
	int          taken_cnt  = 0;
	int          res_cnt    = 0;
	int          err_cnt    = 0;

	function automatic hufd_res_t tree_step(int cp, hufd_req_t r);
		hufd_res_t   res;
		int unsigned len, cur, nxt, have, need;
		logic        b;
		res.status = ST_LOAD_OK;
		res.sym    = '0;
		if (r.func == FUNC_LOAD) begin
			len  = (r.code_length > MAX_CODE_LEN) ? MAX_CODE_LEN : r.code_length;
			cur  = 0;
			have = 0;
			for (int i = 0; i < len; i++) begin
				if (have == i) begin
					b   = (len - 1 - i < CODE_W) ? r.code_bits[len - 1 - i] : 1'b0;
					nxt = b ? right_kid[cp][cur] : left_kid[cp][cur];
					if (nxt != 0) begin
						cur = nxt;
						have++;
					end
				end
			end
			need = len - have;
			if (next_node[cp] > NODE_COUNT || need > NODE_COUNT - next_node[cp]) begin
				res.status = ST_FULL;
			end else if (len != 0) begin
				cur = 0;
				for (int i = 0; i < len; i++) begin
					b   = (len - 1 - i < CODE_W) ? r.code_bits[len - 1 - i] : 1'b0;
					nxt = b ? right_kid[cp][cur] : left_kid[cp][cur];
					if (nxt == 0) begin
						nxt = next_node[cp];
						next_node[cp]++;
						left_kid[cp][nxt]  = 0;
						right_kid[cp][nxt] = 0;
						leaf_sym[cp][nxt]  = '0;
						if (b)
							right_kid[cp][cur] = nxt;
						else
							left_kid[cp][cur] = nxt;
					end
					cur = nxt;
				end
				left_kid[cp][cur]  = 0;
				right_kid[cp][cur] = 0;
				leaf_sym[cp][cur]  = r.symbol;
			end
		end else begin
			cur = walk_at[cp];
			nxt = r.stream_bit ? right_kid[cp][cur] : left_kid[cp][cur];
			if (nxt == 0) begin
				res.status  = ST_INVALID;
				walk_at[cp] = 0;
			end else if (left_kid[cp][nxt] == 0 && right_kid[cp][nxt] == 0) begin
				res.status  = ST_SYMBOL;
				res.sym     = leaf_sym[cp][nxt];
				walk_at[cp] = 0;
			end else begin
				res.status  = ST_BIT_TAKEN;
				walk_at[cp] = nxt;
			end
		end
		return res;
	endfunction

	function automatic hufd_req_t load_req(logic [SYM_W-1:0] s, logic [LEN_W-1:0] n,
	                                       logic [CODE_W-1:0] c);
		hufd_req_t r;
		r.func        = FUNC_LOAD;
		r.symbol      = s;
		r.code_length = n;
		r.code_bits   = c;
		r.stream_bit  = 1'($urandom_range(1));
		return r;
	endfunction

	function automatic hufd_req_t bit_req(logic b);
		hufd_req_t r;
		r.func        = FUNC_DECODE;
		r.symbol      = SYM_W'($urandom);
		r.code_length = LEN_W'($urandom);
		r.code_bits   = $urandom;
		r.stream_bit  = b;
		return r;
	endfunction

	function automatic hufd_res_t plan_req(hufd_req_t r);
		queued_req_t q;
		q.req      = r;
		q.mode     = gen_mode;
		q.drain    = drain_next;
		drain_next = 1'b0;
		req_queue.push_back(q);
		queued_cnt++;
		return tree_step(STIM_COPY, r);
	endfunction

	task automatic send_noise(int n, int cap);
		int len;
		for (int i = 0; i < n; i++) begin
			len = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(8);
			if ($urandom_range(1) == 1 &&
			    next_node[STIM_COPY] + ((len > MAX_CODE_LEN) ? MAX_CODE_LEN : len) <= cap)
				void'(plan_req(load_req(SYM_W'($urandom), LEN_W'(len), $urandom)));
			else
				void'(plan_req(bit_req(1'($urandom_range(1)))));
		end
	endtask

	// Code words of the current table, most significant bit first. A word is
	// now and then cut short and followed by stray requests.
	task automatic play_stream(int words);
		int                k, cut;
		logic [CODE_W-1:0] c;
		for (int w = 0; w < words; w++) begin
			while (walk_at[STIM_COPY] != 0)
				void'(plan_req(bit_req(1'($urandom_range(1)))));
			k   = $urandom_range(tab_len.size() - 1);
			c   = tab_code[k];
			cut = ($urandom_range(9) == 0) ? $urandom_range(tab_len[k] - 1) : tab_len[k];
			for (int j = 0; j < cut; j++)
				void'(plan_req(bit_req(c[tab_len[k] - 1 - j])));
			if (cut != tab_len[k])
				send_noise($urandom_range(1, 3), NODE_CAP);
		end
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_bus.valid || req_fired) begin
				if (req_queue.size() != 0 && !(req_queue[0].drain && expect_q.size() != 0) &&
				    $urandom_range(99) >= ((req_queue[0].mode == MODE_SLOW_SRC) ? 78 :
				                           (req_queue[0].mode == MODE_BOTH) ? 20 : 0)) begin
					head                 = req_queue.pop_front();
					run_mode             = head.mode;
					req_bus.valid       <= 1'b1;
					req_bus.func        <= head.req.func;
					req_bus.symbol      <= head.req.symbol;
					req_bus.code_length <= head.req.code_length;
					req_bus.code_bits   <= head.req.code_bits;
					req_bus.stream_bit  <= head.req.stream_bit;
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
			res_bus.ready <= ($urandom_range(99) >= ((run_mode == MODE_SLOW_SINK) ? 78 :
			                                        (run_mode == MODE_BOTH) ? 20 : 0));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			req_fired = req_bus.valid && req_bus.ready;
			if (req_fired) begin
				seen.func        = func_t'(req_bus.func);
				seen.symbol      = req_bus.symbol;
				seen.code_length = req_bus.code_length;
				seen.code_bits   = req_bus.code_bits;
				seen.stream_bit  = req_bus.stream_bit;
				expect_q.push_back(tree_step(CHECK_COPY, seen));
				taken_cnt++;
			end
			if (res_bus.valid && res_bus.ready) begin
				if (expect_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("result %0d not expected: status %0d symbol %02h",
						         res_cnt, res_bus.status, res_bus.decoded_symbol);
				end else begin
					want = expect_q.pop_front();
					if (res_bus.status !== want.status ||
					    res_bus.decoded_symbol !== want.sym) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("result %0d: status %0d symbol %02h, expected status %0d symbol %02h",
							         res_cnt, res_bus.status, res_bus.decoded_symbol,
							         want.status, want.sym);
					end
				end
				res_cnt++;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tb_huffman_tree_bit_decoder_core: errors");
		$finish;
	end

	initial begin
		logic [CODE_W-1:0] new_code [$];
		int                new_len  [$];
		logic [CODE_W-1:0] c;
		hufd_res_t         o;
		int                base, splits, depth, pick, l, total, full_seen;

		req_bus.valid       = 1'b0;
		req_bus.func        = FUNC_LOAD;
		req_bus.symbol      = '0;
		req_bus.code_length = '0;
		req_bus.code_bits   = '0;
		req_bus.stream_bit  = 1'b0;
		res_bus.ready       = 1'b0;

		// Directed opening on an empty tree.
		void'(plan_req(bit_req(1'b0)));
		void'(plan_req(bit_req(1'b1)));
		void'(plan_req(load_req(8'hA5, 6'd0, 32'hFFFF_FFFF)));
		void'(plan_req(load_req(8'h00, 6'd1, 32'hFFFF_FFFE)));
		void'(plan_req(load_req(8'hFF, 6'd2, 32'h0000_0002)));
		void'(plan_req(bit_req(1'b0)));
		void'(plan_req(bit_req(1'b1)));
		void'(plan_req(bit_req(1'b0)));
		void'(plan_req(bit_req(1'b1)));
		void'(plan_req(bit_req(1'b1)));
		// A load in the middle of a walk leaves the walk where it is.
		void'(plan_req(bit_req(1'b1)));
		void'(plan_req(load_req(8'h3C, 6'd2, 32'h0000_0003)));
		void'(plan_req(bit_req(1'b1)));
		// The code passes through the leaf of symbol 00.
		void'(plan_req(load_req(8'h11, 6'd2, 32'h0000_0001)));
		void'(plan_req(bit_req(1'b0)));
		void'(plan_req(bit_req(1'b1)));
		void'(plan_req(bit_req(1'b0)));
		void'(plan_req(bit_req(1'b0)));
		// The walk rests on a node that is then reloaded as a leaf.
		void'(plan_req(bit_req(1'b1)));
		void'(plan_req(load_req(8'h77, 6'd1, 32'h0000_0001)));
		void'(plan_req(bit_req(1'b0)));
		void'(plan_req(bit_req(1'b1)));
		// Longest codes, one of them with a length beyond the limit.
		void'(plan_req(load_req(8'h5A, 6'd63, 32'hFFFF_FFFF)));
		void'(plan_req(load_req(8'hC3, 6'd32, 32'h0000_0000)));

		base       = queued_cnt;
		drain_next = 1'b1;
		for (int rnd = 0; queued_cnt - base < RANDOM_ITEMS; rnd++) begin
			gen_mode = 2'(rnd % 4);
			if ($urandom_range(9) == 0)
				drain_next = 1'b1;
			if (tab_len.size() == 0 || $urandom_range(3) != 0) begin
				if (tab_len.size() == 0 || $urandom_range(1) == 0) begin
					new_code.delete();
					new_len.delete();
					new_code.push_back('0);
					new_len.push_back(0);
					splits = $urandom_range(1, 7);
					depth  = $urandom_range(2, 6);
					for (int s = 0; s < splits * 4 && new_len.size() <= splits; s++) begin
						pick = $urandom_range(new_len.size() - 1);
						if (new_len[pick] < depth) begin
							c = new_code[pick];
							l = new_len[pick];
							new_code.delete(pick);
							new_len.delete(pick);
							new_code.push_back({c[CODE_W-2:0], 1'b0});
							new_len.push_back(l + 1);
							new_code.push_back({c[CODE_W-2:0], 1'b1});
							new_len.push_back(l + 1);
						end
					end
					total = 0;
					foreach (new_len[k])
						total += new_len[k];
					if (next_node[STIM_COPY] + total <= NODE_CAP) begin
						tab_code = new_code;
						tab_len  = new_len;
						foreach (tab_len[k]) begin
							if ($urandom_range(7) == 0)
								void'(plan_req(bit_req(1'($urandom_range(1)))));
							void'(plan_req(load_req(SYM_W'($urandom), LEN_W'(tab_len[k]),
							                        tab_code[k] | ($urandom << tab_len[k]))));
						end
					end
				end
				play_stream($urandom_range(3, 20));
			end else begin
				send_noise($urandom_range(4, 24), NODE_CAP);
			end
		end

		// Fill the node store until loads are refused, then keep going.
		drain_next = 1'b1;
		full_seen  = 0;
		for (int i = 0; i < 80 && full_seen < 3; i++) begin
			gen_mode = 2'(i % 4);
			o = plan_req(load_req(SYM_W'($urandom), LEN_W'($urandom_range(MAX_CODE_LEN, 63)),
			                      $urandom));
			if (o.status == ST_FULL)
				full_seen++;
			void'(plan_req(bit_req(1'($urandom_range(1)))));
		end
		void'(plan_req(load_req(SYM_W'($urandom), LEN_W'(tab_len[0]), tab_code[0])));
		play_stream(10);
		send_noise(40, NODE_COUNT + MAX_CODE_LEN);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		while (taken_cnt != queued_cnt)
			@(negedge clk);
		while (expect_q.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (err_cnt == 0)
			$display("tb_huffman_tree_bit_decoder_core: clean");
		else
			$display("tb_huffman_tree_bit_decoder_core: errors");
		$finish;
	end

endmodule
